/* rtl/biq_pkg.sv */
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, formats and helpers for the biquad IIR filter.
// ----------------------------------------------------------------------------
package biq_pkg;

    // Default widths of the sample and coefficient formats
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // Delay state format: 48 bits, 40 fraction bits
    localparam int DELAY_BITS = 48;
    localparam int DELAY_FRAC = 40;

    // Width of a scaled product term and of the sums built from it
    localparam int TERM_BITS  = 58;

    // Digit width of the shared multiplier; two digits cover a delay word
    localparam int DIGIT_BITS = 24;

    // Configuration register indexes
    localparam logic [2:0] REG_COEF_B0 = 3'd0;
    localparam logic [2:0] REG_COEF_B1 = 3'd1;
    localparam logic [2:0] REG_COEF_B2 = 3'd2;
    localparam logic [2:0] REG_COEF_A1 = 3'd3;
    localparam logic [2:0] REG_COEF_A2 = 3'd4;
    localparam logic [2:0] REG_BYPASS  = 3'd5;

    // Product slots in the order the sequencer runs them
    localparam logic [2:0] PROD_B0X = 3'd0;
    localparam logic [2:0] PROD_B1X = 3'd1;
    localparam logic [2:0] PROD_B2X = 3'd2;
    localparam logic [2:0] PROD_A1Y = 3'd3;
    localparam logic [2:0] PROD_A2Y = 3'd4;

    // Sequencer steps at which a finished product is consumed
    localparam logic [3:0] STEP_Y    = 4'd2;
    localparam logic [3:0] STEP_N1   = 4'd4;
    localparam logic [3:0] STEP_N2   = 4'd6;
    localparam logic [3:0] STEP_D1   = 4'd8;
    localparam logic [3:0] STEP_LAST = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_OUT
    } t_state;

    // Saturate a term-width sum to the delay format
    function automatic logic signed [DELAY_BITS-1:0] sat_delay(
        input logic signed [TERM_BITS-1:0] v
    );
        logic signed [DELAY_BITS-1:0] res;
        if (v[TERM_BITS-1:DELAY_BITS-1] == '0 || v[TERM_BITS-1:DELAY_BITS-1] == '1) begin
            res = v[DELAY_BITS-1:0];
        end else if (v[TERM_BITS-1]) begin
            res = {1'b1, {(DELAY_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(DELAY_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* rtl/biq_ifs.sv */
// ----------------------------------------------------------------------------
// biq_in_if / biq_out_if
// Valid/ready sample channels into and out of the biquad filter.
// ----------------------------------------------------------------------------
interface biq_in_if
    import biq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if
    import biq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/biquad_iir_filter.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR filter, transposed direct form II, one shared MAC.
// ----------------------------------------------------------------------------
// A filtered sample runs a MAC sequence from acceptance to a valid output word:
// one multiplier of COEF_BITS x 25 bits computes each of the five products
// (b0*x, b1*x, b2*x, a1*y, a2*y) in two digit passes, and a final step
// closes the second delay and rounds the output. The input is ready again
// the cycle after the output word is taken; no new sample enters before
// that. With bypass set a sample goes straight to the output register and
// the delays hold. Only one sample is in flight; coefficients and bypass
// may be written only while the filter is idle.
// ----------------------------------------------------------------------------
module biquad_iir_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_addr,
    input  logic [COEF_BITS-1:0] i_cfg_data,
    biq_in_if.sink               i_smp,
    biq_out_if.source            o_smp
);

    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int FF_SHIFT    = SAMPLE_FRAC + COEF_FRAC - DELAY_FRAC;
    localparam int FF_DN       = (FF_SHIFT > 0) ? FF_SHIFT : 0;
    localparam int FF_UP       = (FF_SHIFT < 0) ? -FF_SHIFT : 0;
    localparam int OUT_SHIFT   = DELAY_FRAC - SAMPLE_FRAC;
    localparam int PP_BITS     = COEF_BITS + DIGIT_BITS + 1;
    localparam int PROD_BITS   = COEF_BITS + 2 * DIGIT_BITS;
    localparam logic [DELAY_BITS:0] HALF_LSB = (DELAY_BITS+1)'(1) << (OUT_SHIFT - 1);

    // Control and configuration registers
    t_state                        r_state, n_state;
    logic [3:0]                    r_step, n_step;
    logic signed [COEF_BITS-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                          r_bypass;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [DELAY_BITS-1:0]  r_y;
    logic signed [DELAY_BITS-1:0]  r_d1, r_d2;
    logic signed [TERM_BITS-1:0]   r_n1, r_n2;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic                          in_fire, out_fire;
    logic [2:0]                    slot;
    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [DELAY_BITS-1:0]  mul_word;
    logic signed [DIGIT_BITS:0]    mul_digit;
    logic signed [PP_BITS-1:0]     pp;
    logic signed [PROD_BITS-1:0]   pp_ext;
    logic signed [PROD_BITS-1:0]   ff_full, fb_full;
    logic signed [TERM_BITS-1:0]   ff_term, fb_term;
    logic signed [TERM_BITS-1:0]   d1_ext, d2_ext;
    logic signed [DELAY_BITS:0]    rnd;
    logic signed [DELAY_BITS:0]    rnd_sh;
    logic signed [SAMPLE_BITS-1:0] y_out;

    assign in_fire  = i_smp.valid && i_smp.ready;
    assign out_fire = o_smp.valid && o_smp.ready;

    assign i_smp.ready      = (r_state == ST_IDLE);
    assign o_smp.valid      = (r_state == ST_OUT);
    assign o_smp.sample_out = r_out;

    // Select coefficient and multiplicand for the running product
    assign slot = r_step[3:1];

    always_comb begin
        case (slot)
            PROD_B0X: mul_coef = r_b0;
            PROD_B1X: mul_coef = r_b1;
            PROD_B2X: mul_coef = r_b2;
            PROD_A1Y: mul_coef = r_a1;
            PROD_A2Y: mul_coef = r_a2;
            default:  mul_coef = '0;
        endcase
        if (slot == PROD_A1Y || slot == PROD_A2Y) begin
            mul_word = r_y;
        end else begin
            mul_word = {{(DELAY_BITS-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
        end
        // Low digit unsigned, high digit signed
        if (r_step[0]) begin
            mul_digit = {mul_word[DELAY_BITS-1], mul_word[DELAY_BITS-1:DIGIT_BITS]};
        end else begin
            mul_digit = {1'b0, mul_word[DIGIT_BITS-1:0]};
        end
    end

    // Shared multiplier
    assign pp     = mul_coef * mul_digit;
    assign pp_ext = {{(PROD_BITS-PP_BITS){pp[PP_BITS-1]}}, pp};

    // Scale finished products to the delay format (floor)
    assign ff_full = (r_prod >>> FF_DN) <<< FF_UP;
    assign fb_full = r_prod >>> COEF_FRAC;
    assign ff_term = ff_full[TERM_BITS-1:0];
    assign fb_term = fb_full[TERM_BITS-1:0];
    assign d1_ext  = {{(TERM_BITS-DELAY_BITS){r_d1[DELAY_BITS-1]}}, r_d1};
    assign d2_ext  = {{(TERM_BITS-DELAY_BITS){r_d2[DELAY_BITS-1]}}, r_d2};

    // Round half up to the sample format and saturate
    assign rnd    = $signed({r_y[DELAY_BITS-1], r_y} + HALF_LSB);
    assign rnd_sh = rnd >>> OUT_SHIFT;

    always_comb begin
        if (rnd_sh[DELAY_BITS:SAMPLE_BITS-1] == '0 ||
            rnd_sh[DELAY_BITS:SAMPLE_BITS-1] == '1) begin
            y_out = rnd_sh[SAMPLE_BITS-1:0];
        end else if (rnd_sh[DELAY_BITS]) begin
            y_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_fire) begin
                    n_state = r_bypass ? ST_OUT : ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= COEF_BITS'(1) <<< COEF_FRAC;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_COEF_B0: r_b0     <= i_cfg_data;
                REG_COEF_B1: r_b1     <= i_cfg_data;
                REG_COEF_B2: r_b2     <= i_cfg_data;
                REG_COEF_A1: r_a1     <= i_cfg_data;
                REG_COEF_A2: r_a2     <= i_cfg_data;
                REG_BYPASS:  r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Delay state: updated only by the filter sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (r_state == ST_MAC) begin
            if (r_step == STEP_D1) begin
                r_d1 <= sat_delay(r_n1 - fb_term);
            end
            if (r_step == STEP_LAST) begin
                r_d2 <= sat_delay(r_n2 - fb_term);
            end
        end
    end

    // Capture the sample, run the MAC and fold finished products
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_smp.sample_in;
            if (r_bypass) begin
                r_out <= i_smp.sample_in;
            end
        end
        if (r_state == ST_MAC) begin
            if (r_step[0]) begin
                r_prod <= r_prod + (pp_ext <<< DIGIT_BITS);
            end else begin
                r_prod <= pp_ext;
            end
            case (r_step)
                STEP_Y:    r_y   <= sat_delay(ff_term + d1_ext);
                STEP_N1:   r_n1  <= ff_term + d2_ext;
                STEP_N2:   r_n2  <= ff_term;
                STEP_LAST: r_out <= y_out;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/biq_checker.sv */
// ----------------------------------------------------------------------------
// biq_checker
// Port-level assertions for the biquad filter, bound to its top level.
// ----------------------------------------------------------------------------
module biq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // Hold the output word until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped before it was taken");

    // Come out of reset with no pending output word
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Go busy once a sample is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready after taking a sample");

    // Accept no sample while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // Deliver one result per sample
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("second result without a new sample");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_smp.valid),
    .i_out_ready (o_smp.ready)
);

/* tb/biquad_iir_filter_checker.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter_checker
// Tracks register writes and both sample channels of the biquad filter. It
// keeps its own fixed-point copy of the filter and its two delays, predicts
// the word for every accepted input sample, and compares each output word in
// order. It reports a failure count and the number of words still expected.
// ----------------------------------------------------------------------------
module biquad_iir_filter_checker
    import biq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_addr,
    input  logic [COEF_BITS_DEF-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [SAMPLE_BITS_DEF-1:0] i_in_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [SAMPLE_BITS_DEF-1:0] i_out_sample,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int COEF_BITS   = COEF_BITS_DEF;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    // Shift that brings a coefficient-times-sample product to delay format
    localparam int FF_SHIFT    = SAMPLE_FRAC + COEF_FRAC - DELAY_FRAC;
    // Shift from delay format down to the output sample format
    localparam int OUT_SHIFT   = DELAY_FRAC - SAMPLE_FRAC;

    // Wide enough for any coefficient times a saturated delay value
    typedef logic signed [95:0] t_wide;

    logic signed [COEF_BITS-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
    logic                         pass_through;
    logic signed [DELAY_BITS-1:0] hist1_q, hist2_q;
    logic [SAMPLE_BITS-1:0]       predicted_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // Product floored to delay format (arithmetic shift rounds toward minus infinity)
    function automatic t_wide scaled_product(input t_wide a, input t_wide b, input int shift);
        t_wide p;
        p = a * b;
        return p >>> shift;
    endfunction

    function automatic t_wide clamp_to_bits(input t_wide v, input int bits);
        t_wide top_val;
        t_wide bot_val;
        top_val = 1;
        top_val = (top_val <<< (bits - 1)) - 1;
        bot_val = -top_val - 1;
        if (v > top_val) begin
            return top_val;
        end else if (v < bot_val) begin
            return bot_val;
        end
        return v;
    endfunction

    // Advance the delays by one sample and return the filtered word
    function automatic logic [SAMPLE_BITS-1:0] next_filtered_word(
        input logic signed [SAMPLE_BITS-1:0] word
    );
        t_wide x, y, n1, n2, rnd, o;
        if (pass_through) begin
            return word;
        end
        x   = word;
        y   = clamp_to_bits(scaled_product(b0_q, x, FF_SHIFT) + hist1_q, DELAY_BITS);
        n1  = scaled_product(b1_q, x, FF_SHIFT) - scaled_product(a1_q, y, COEF_FRAC) + hist2_q;
        n2  = scaled_product(b2_q, x, FF_SHIFT) - scaled_product(a2_q, y, COEF_FRAC);
        n1  = clamp_to_bits(n1, DELAY_BITS);
        n2  = clamp_to_bits(n2, DELAY_BITS);
        hist1_q = n1[DELAY_BITS-1:0];
        hist2_q = n2[DELAY_BITS-1:0];
        // Round half up to the output format, then saturate
        rnd = 1;
        rnd = rnd <<< (OUT_SHIFT - 1);
        o   = clamp_to_bits((y + rnd) >>> OUT_SHIFT, SAMPLE_BITS);
        return o[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [SAMPLE_BITS-1:0] want;
        if (!i_rst_n) begin
            // Reset values: unity b0, other taps zero, bypass on, delays cleared
            b0_q         = '0;
            b0_q[COEF_FRAC] = 1'b1;
            b1_q         = '0;
            b2_q         = '0;
            a1_q         = '0;
            a2_q         = '0;
            pass_through = 1'b1;
            hist1_q      = '0;
            hist2_q      = '0;
            predicted_words.delete();
        end else begin
            // Track register writes; spare indexes change nothing
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_COEF_B0: b0_q = i_cfg_data;
                    REG_COEF_B1: b1_q = i_cfg_data;
                    REG_COEF_B2: b2_q = i_cfg_data;
                    REG_COEF_A1: a1_q = i_cfg_data;
                    REG_COEF_A2: a2_q = i_cfg_data;
                    REG_BYPASS:  pass_through = i_cfg_data[0];
                    default: ;
                endcase
            end
            // Compare an output word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    report_mismatch($sformatf("output word %0d with no sample pending",
                                              $signed(i_out_sample)));
                end else begin
                    want = predicted_words.pop_front();
                    if (i_out_sample !== want) begin
                        report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                                  $signed(i_out_sample), $signed(want)));
                    end
                end
            end
            // Predict the word for an accepted input sample
            if (i_in_valid && i_in_ready) begin
                predicted_words.push_back(next_filtered_word(i_in_sample));
            end
        end
        o_pending <= predicted_words.size();
    end

endmodule

/* tb/biquad_iir_filter_test.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter_test
// Stimulus and verdict for the biquad filter. Runs a directed set of extreme
// samples, then random samples through several coefficient settings (stable,
// extreme, random, bypass toggled mid-stream), with random idling on both
// channels and one long output hold-off. Checking lives in the checker.
// ----------------------------------------------------------------------------
module biquad_iir_filter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import biq_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    // Spare register indexes, writes to them must be ignored
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = 24'sh800000;

    localparam logic [COEF_BITS_DEF-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS_DEF-1:0] COEF_MIN = 32'h8000_0000;

    // Stable low-pass in Q4.28: b = 0.2 0.4 0.2, a1 = -0.6, a2 = 0.2
    localparam logic [COEF_BITS_DEF-1:0] LP_B0 = 32'sd53687091;
    localparam logic [COEF_BITS_DEF-1:0] LP_B1 = 32'sd107374182;
    localparam logic [COEF_BITS_DEF-1:0] LP_B2 = 32'sd53687091;
    localparam logic [COEF_BITS_DEF-1:0] LP_A1 = -32'sd161061274;
    localparam logic [COEF_BITS_DEF-1:0] LP_A2 = 32'sd53687091;

    // Bypass words: bit 0 decides, upper bits are don't-care
    localparam logic [COEF_BITS_DEF-1:0] BYPASS_ON      = 32'h0000_0001;
    localparam logic [COEF_BITS_DEF-1:0] BYPASS_OFF     = 32'h0000_0000;
    localparam logic [COEF_BITS_DEF-1:0] BYPASS_OFF_DIRTY = 32'hFFFF_FFFE;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [2:0]               cfg_addr;
    logic [COEF_BITS_DEF-1:0] cfg_data;
    int                       fail_count;
    int                       pending;
    bit                       quiet_phase  = 1'b0;
    bit                       hold_off_req = 1'b0;

    biq_in_if  in_ch ();
    biq_out_if out_ch ();

    biquad_iir_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_smp      (in_ch),
        .o_smp      (out_ch)
    );

    biquad_iir_filter_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_sample  (in_ch.sample_in),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_sample (out_ch.sample_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random ready bursts, one long hold-off on request
    initial begin
        int burst;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (quiet_phase || $urandom_range(0, 2) != 0) begin
                out_ch.ready <= 1'b1;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [COEF_BITS_DEF-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= index;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_filter(
        input logic [COEF_BITS_DEF-1:0] b0, b1, b2, a1, a2, bypass_word
    );
        write_reg(REG_COEF_B0, b0);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
        write_reg(REG_BYPASS, bypass_word);
    endtask

    // Offer one word, hold it until taken, then maybe idle for a burst
    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] word);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= word;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain_filter();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] random_sample();
        logic signed [SAMPLE_BITS_DEF-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    w = SAMPLE_BITS_DEF'($urandom_range(0, 512) - 256);
            default: w = SAMPLE_BITS_DEF'($urandom());
        endcase
        return w;
    endfunction

    // Full-range coefficient, or one within +-2.0
    function automatic logic [COEF_BITS_DEF-1:0] random_coef(input bit full);
        if (full) begin
            return $urandom();
        end
        return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endfunction

    task automatic run_random(input int count, input int hold_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) begin
                hold_off_req = 1'b1;
            end
            send_sample(random_sample());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_addr        <= REG_COEF_B0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: bypass passes extremes and bit patterns unchanged
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(24'sh555555);
        send_sample(24'shAAAAAA);
        drain_filter();

        // Spare indexes must not disturb anything; then filter with reset taps
        write_reg(REG_SPARE_6, $urandom());
        write_reg(REG_SPARE_7, $urandom());
        write_reg(REG_BYPASS, BYPASS_OFF);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-24'sd1);
        drain_filter();

        // Low-pass: impulse, then sustained full scale to saturate the output
        program_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2, BYPASS_OFF_DIRTY);
        send_sample(SAMPLE_MAX);
        repeat (3) send_sample('0);
        send_sample(SAMPLE_MIN);
        repeat (5) send_sample(SAMPLE_MAX);
        repeat (5) send_sample(SAMPLE_MIN);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        run_random(150, 40);
        drain_filter();

        // Extreme taps: accumulator and delays run into saturation
        program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, BYPASS_OFF);
        run_random(100, -1);
        drain_filter();
        program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, BYPASS_OFF);
        run_random(60, -1);
        drain_filter();

        // Bypass mid-stream must hold the delays for the return to filtering
        program_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2, BYPASS_OFF);
        run_random(40, -1);
        drain_filter();
        write_reg(REG_BYPASS, BYPASS_ON);
        run_random(50, -1);
        drain_filter();
        write_reg(REG_BYPASS, BYPASS_OFF);
        run_random(50, -1);
        drain_filter();

        // Random coefficient sets, full range and moderate
        for (int s = 0; s < 4; s++) begin
            program_filter(random_coef(s[0]), random_coef(s[0]), random_coef(s[0]),
                           random_coef(s[0]), random_coef(s[0]), BYPASS_OFF);
            run_random(60, -1);
            drain_filter();
        end

        // Closing stretch without idling on either side
        quiet_phase = 1'b1;
        program_filter(random_coef(1'b0), random_coef(1'b0), random_coef(1'b0),
                       random_coef(1'b0), random_coef(1'b0), BYPASS_OFF);
        run_random(150, -1);
        drain_filter();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
